[src/host_key_to_matrix_keyboard_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros
// Implication checks for the keyboard matrix block, removable with
// NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef HOST_KEY_TO_MATRIX_KEYBOARD_ASSERT_SVH
`define HOST_KEY_TO_MATRIX_KEYBOARD_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define HKM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("hkm: implication check failed");
`define HKM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("hkm: next-cycle check failed");
`else
`define HKM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define HKM_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[src/hkm_pkg.sv]
// ----------------------------------------------------------------------------
// hkm_pkg
// Sizes, codes, types and matrix helpers shared by the keyboard matrix block.
// ----------------------------------------------------------------------------
package hkm_pkg;

	localparam int HELD_DEPTH  = 8;
	localparam int KEY_BITS    = 8;
	localparam int MATRIX_ROWS = 8;

	localparam int IDX_W     = KEY_BITS + 2;
	localparam int MAP_DEPTH = 1 << IDX_W;
	localparam int CNT_W     = $clog2(HELD_DEPTH + 1);
	localparam int ENT_W     = 8;
	localparam int POS_W     = 6;
	localparam int ACT_W     = 3;
	localparam int CFG_IDX_W = 8;

	localparam logic [ACT_W-1:0] ACT_PRESS   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd1;
	localparam logic [ACT_W-1:0] ACT_SCAN    = 3'd2;
	localparam logic [ACT_W-1:0] ACT_READ    = 3'd3;
	localparam logic [ACT_W-1:0] ACT_MAP     = 3'd4;

	localparam logic [CFG_IDX_W-1:0] REG_LSHIFT  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RSHIFT  = 8'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ALTGR   = 8'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RESTORE = 8'd3;

	localparam logic [7:0] LSHIFT_RST  = 8'd225;
	localparam logic [7:0] RSHIFT_RST  = 8'd229;
	localparam logic [7:0] ALTGR_RST   = 8'd230;
	localparam logic [7:0] RESTORE_RST = 8'd75;

	localparam logic [POS_W-1:0] LSHIFT_POS = 6'd15;
	localparam logic [POS_W-1:0] RSHIFT_POS = 6'd52;

	localparam int ENT_VALID_BIT = 7;
	localparam int ENT_SHIFT_BIT = 6;

	localparam logic [7:0] COL_IDLE = 8'hFF;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [7:0][7:0] matrix_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctrl_t;

	// Set or clear one matrix bit; rows past the matrix are ignored.
	function automatic matrix_t put_matrix(matrix_t m, logic [POS_W-1:0] pos, logic level);
		matrix_t r;
		logic [2:0] row;
		r = m;
		row = pos[5:3];
		if ({1'b0, row} < 4'(MATRIX_ROWS))
			r[row][pos[2:0]] = level;
		return r;
	endfunction

	function automatic logic [7:0] column_read(matrix_t m, logic [7:0] sel);
		logic [7:0] acc;
		acc = '0;
		for (int r = 0; r < 8; r++) begin
			if (r < MATRIX_ROWS && !sel[r])
				acc = acc | m[r];
		end
		return ~acc;
	endfunction

endpackage

[src/hkm_ifs.sv]
// ----------------------------------------------------------------------------
// hkm channel interfaces
// Event, result and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hkm_in_if;
	import hkm_pkg::*;
	logic             valid;
	logic             ready;
	logic [ACT_W-1:0] action;
	logic [7:0]       host_key;
	logic [7:0]       scan_value;
	logic             with_shift;
	logic             with_altgr;
	logic             entry_valid;
	logic [POS_W-1:0] matrix_pos;
	logic             target_shift;
	modport source(output valid, action, host_key, scan_value, with_shift, with_altgr,
		entry_valid, matrix_pos, target_shift, input ready);
	modport sink(input valid, action, host_key, scan_value, with_shift, with_altgr,
		entry_valid, matrix_pos, target_shift, output ready);
endinterface

interface hkm_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] column_data;
	logic       restore_pulse;
	logic       held_full;
	modport source(output valid, column_data, restore_pulse, held_full, input ready);
	modport sink(input valid, column_data, restore_pulse, held_full, output ready);
endinterface

interface hkm_cfg_if;
	import hkm_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] idx;
	logic [7:0]           data;
	modport source(output valid, idx, data, input ready);
	modport sink(input valid, idx, data, output ready);
endinterface

[src/host_key_to_matrix_keyboard.sv]
// ----------------------------------------------------------------------------
// host_key_to_matrix_keyboard
// Host key events to an 8x8 scanned keyboard matrix.
// ----------------------------------------------------------------------------
// After reset the block sweeps the translation RAM to zero, one entry per
// cycle, and takes no item until that is done; register writes are taken at
// any time. Items then go one at a time: scan write, column read, map write
// and unused actions go straight to the done state; a press goes through the
// apply state (registered read of the translation RAM), a release through the
// find state (first-match search along the held-list cell chain, then the RAM
// read) and then apply. A result waits in the output register; the next item
// is accepted meanwhile and finishes once that register is free.

`include "host_key_to_matrix_keyboard_assert.svh"

module host_key_to_matrix_keyboard (
	input  logic      clk,
	input  logic      arst_n,
	hkm_in_if.sink    key_in,
	hkm_out_if.source res_out,
	hkm_cfg_if.sink   cfg
);
	import hkm_pkg::*;

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_FIND  = 3'd2;
	localparam logic [2:0] S_APPLY = 3'd3;
	localparam logic [2:0] S_DONE  = 3'd4;

	logic [2:0]       state_q;
	logic [IDX_W-1:0] clr_q;
	logic [7:0]       lsc_q, rsc_q, agc_q, rstc_q;
	logic [7:0]       scan_q;
	matrix_t          rows_q;
	logic [CNT_W-1:0] held_cnt_q;
	logic             lsd_q, rsd_q, asd_q, agd_q;
	logic             out_valid_q;

	logic [ACT_W-1:0]      act_q;
	logic [7:0]            key_q;
	idx_t                  idx_q;
	logic [HELD_DEPTH-1:0] rm_q;
	logic [7:0]            res_col_q;
	logic                  res_rst_q, res_full_q;
	logic [7:0]            out_col_q;
	logic                  out_rst_q, out_full_q;

	logic             accept;
	idx_t             press_idx, map_idx, hit_idx;
	logic [ENT_W-1:0] map_entry, ram_rd;
	logic             ram_we, ram_re;
	idx_t             ram_waddr, ram_raddr;
	logic [ENT_W-1:0] ram_wdata;

	matrix_t          mat_nxt;
	logic             lsd_nxt, rsd_nxt, asd_nxt, agd_nxt;
	logic             do_append, do_remove, rst_nxt, full_nxt;
	logic             found;

	logic [HELD_DEPTH:0]  chain;
	idx_t                 cell_idx [HELD_DEPTH];
	logic [KEY_BITS-1:0]  key_part;

	assign accept        = key_in.valid && key_in.ready;
	assign key_in.ready  = (state_q == S_IDLE);
	assign cfg.ready     = 1'b1;

	assign press_idx = {agd_q, asd_q, KEY_BITS'(key_in.host_key)};
	assign map_idx   = {key_in.with_altgr, key_in.with_shift, KEY_BITS'(key_in.host_key)};
	assign map_entry = key_in.entry_valid ?
		{1'b1, key_in.target_shift, key_in.matrix_pos} : '0;

	assign ram_we    = (state_q == S_CLEAR) || (accept && key_in.action == ACT_MAP);
	assign ram_waddr = (state_q == S_CLEAR) ? clr_q : map_idx;
	assign ram_wdata = (state_q == S_CLEAR) ? '0 : map_entry;
	assign ram_re    = (accept && key_in.action == ACT_PRESS) || (state_q == S_FIND);
	assign ram_raddr = (state_q == S_FIND) ? hit_idx : press_idx;

	hkm_map_ram #(.AW(IDX_W), .DW(ENT_W)) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rd)
	);

	// Held list: cell 0 is the oldest entry; a removal pulls later cells left.
	assign key_part = KEY_BITS'(key_q);
	assign chain[0] = 1'b0;

	for (genvar i = 0; i < HELD_DEPTH; i++) begin : g_cell
		cell_ctrl_t ctrl;
		idx_t       nxt;
		assign ctrl.load  = do_append && (held_cnt_q == CNT_W'(i));
		assign ctrl.shift = do_remove && rm_q[i];
		if (i == HELD_DEPTH - 1) begin : g_last
			assign nxt = cell_idx[i];
		end else begin : g_mid
			assign nxt = cell_idx[i+1];
		end
		hkm_held_cell u_cell (
			.clk       (clk),
			.ctrl      (ctrl),
			.load_idx  (idx_q),
			.next_idx  (nxt),
			.live      (CNT_W'(i) < held_cnt_q),
			.key       (key_part),
			.match_in  (chain[i]),
			.match_out (chain[i+1]),
			.idx       (cell_idx[i])
		);
	end

	always_comb begin
		hit_idx = '0;
		for (int i = 0; i < HELD_DEPTH; i++) begin
			if (chain[i+1] && !chain[i])
				hit_idx = hit_idx | cell_idx[i];
		end
	end

	assign found = rm_q[HELD_DEPTH-1];

	// Effect of a press or release once its map entry is in hand.
	always_comb begin
		mat_nxt   = rows_q;
		lsd_nxt   = lsd_q;
		rsd_nxt   = rsd_q;
		asd_nxt   = asd_q;
		agd_nxt   = agd_q;
		do_append = 1'b0;
		do_remove = 1'b0;
		rst_nxt   = 1'b0;
		full_nxt  = 1'b0;
		if (state_q == S_APPLY) begin
			if (act_q == ACT_PRESS) begin
				if (key_q == rstc_q) begin
					rst_nxt = 1'b1;
				end else if (key_q == lsc_q) begin
					lsd_nxt = 1'b1;
					asd_nxt = 1'b1;
					mat_nxt = put_matrix(rows_q, LSHIFT_POS, 1'b1);
				end else if (key_q == rsc_q) begin
					rsd_nxt = 1'b1;
					asd_nxt = 1'b1;
					mat_nxt = put_matrix(rows_q, RSHIFT_POS, 1'b1);
				end else if (key_q == agc_q) begin
					agd_nxt = 1'b1;
				end else if (ram_rd[ENT_VALID_BIT]) begin
					mat_nxt = put_matrix(put_matrix(put_matrix(rows_q, RSHIFT_POS, 1'b0),
						LSHIFT_POS, ram_rd[ENT_SHIFT_BIT]), ram_rd[POS_W-1:0], 1'b1);
					if (held_cnt_q < CNT_W'(HELD_DEPTH))
						do_append = 1'b1;
					else
						full_nxt = 1'b1;
				end
			end else begin
				if (key_q == lsc_q) begin
					lsd_nxt = 1'b0;
					asd_nxt = 1'b0;
					mat_nxt = put_matrix(rows_q, LSHIFT_POS, 1'b0);
				end else if (key_q == rsc_q) begin
					rsd_nxt = 1'b0;
					asd_nxt = 1'b0;
					mat_nxt = put_matrix(rows_q, RSHIFT_POS, 1'b0);
				end else if (key_q == agc_q) begin
					agd_nxt = 1'b0;
				end else if (found && ram_rd[ENT_VALID_BIT]) begin
					mat_nxt = put_matrix(put_matrix(put_matrix(rows_q, ram_rd[POS_W-1:0], 1'b0),
						LSHIFT_POS, lsd_q), RSHIFT_POS, rsd_q);
					do_remove = 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			lsc_q       <= LSHIFT_RST;
			rsc_q       <= RSHIFT_RST;
			agc_q       <= ALTGR_RST;
			rstc_q      <= RESTORE_RST;
			scan_q      <= 8'hFF;
			rows_q      <= '0;
			held_cnt_q  <= '0;
			lsd_q       <= 1'b0;
			rsd_q       <= 1'b0;
			asd_q       <= 1'b0;
			agd_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.idx)
					REG_LSHIFT:  lsc_q  <= cfg.data;
					REG_RSHIFT:  rsc_q  <= cfg.data;
					REG_ALTGR:   agc_q  <= cfg.data;
					REG_RESTORE: rstc_q <= cfg.data;
					default: ;
				endcase
			end

			rows_q <= mat_nxt;
			lsd_q  <= lsd_nxt;
			rsd_q  <= rsd_nxt;
			asd_q  <= asd_nxt;
			agd_q  <= agd_nxt;
			if (do_append)
				held_cnt_q <= held_cnt_q + CNT_W'(1);
			else if (do_remove)
				held_cnt_q <= held_cnt_q - CNT_W'(1);

			if (state_q == S_DONE && (!out_valid_q || res_out.ready))
				out_valid_q <= 1'b1;
			else if (res_out.valid && res_out.ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == '1)
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (accept) begin
						unique case (key_in.action)
							ACT_PRESS:   state_q <= S_APPLY;
							ACT_RELEASE: state_q <= S_FIND;
							ACT_SCAN: begin
								scan_q  <= key_in.scan_value;
								state_q <= S_DONE;
							end
							default:     state_q <= S_DONE;
						endcase
					end
				end
				S_FIND:  state_q <= S_APPLY;
				S_APPLY: state_q <= S_DONE;
				S_DONE: begin
					// hold until the output register is free
					if (!out_valid_q || res_out.ready)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q      <= key_in.action;
			key_q      <= key_in.host_key;
			idx_q      <= press_idx;
			res_col_q  <= (key_in.action == ACT_READ) ? column_read(rows_q, scan_q) : COL_IDLE;
			res_rst_q  <= 1'b0;
			res_full_q <= 1'b0;
		end
		if (state_q == S_FIND)
			rm_q <= chain[HELD_DEPTH:1];
		if (state_q == S_APPLY) begin
			res_rst_q  <= rst_nxt;
			res_full_q <= full_nxt;
		end
		if (state_q == S_DONE && (!out_valid_q || res_out.ready)) begin
			out_col_q  <= res_col_q;
			out_rst_q  <= res_rst_q;
			out_full_q <= res_full_q;
		end
	end

	assign res_out.valid         = out_valid_q;
	assign res_out.column_data   = out_col_q;
	assign res_out.restore_pulse = out_rst_q;
	assign res_out.held_full     = out_full_q;

	`HKM_ASSERT_IMP(a_cnt_bound, clk, arst_n, 1'b1, held_cnt_q <= CNT_W'(HELD_DEPTH))
	`HKM_ASSERT_NXT(a_accept_busy, clk, arst_n, accept, state_q != S_IDLE)
	`HKM_ASSERT_IMP(a_remove_cnt, clk, arst_n, do_remove, held_cnt_q != '0)
	`HKM_ASSERT_IMP(a_out_src, clk, arst_n, $rose(out_valid_q), $past(state_q) == S_DONE)
	`HKM_ASSERT_IMP(a_append_room, clk, arst_n, do_append, held_cnt_q < CNT_W'(HELD_DEPTH))
endmodule

[src/hkm_map_ram.sv]
// ----------------------------------------------------------------------------
// hkm_map_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module hkm_map_ram #(
	parameter int AW = 10,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [1 << AW];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end
endmodule

[src/hkm_held_cell.sv]
// ----------------------------------------------------------------------------
// hkm_held_cell
// One slot of the held-key list: stores a map index, takes its right
// neighbor's entry when the list closes a gap, and joins the match chain.
// ----------------------------------------------------------------------------
module hkm_held_cell (
	input  logic                         clk,
	input  hkm_pkg::cell_ctrl_t          ctrl,
	input  hkm_pkg::idx_t                load_idx,
	input  hkm_pkg::idx_t                next_idx,
	input  logic                         live,
	input  logic [hkm_pkg::KEY_BITS-1:0] key,
	input  logic                         match_in,
	output logic                         match_out,
	output hkm_pkg::idx_t                idx
);
	import hkm_pkg::*;

	idx_t idx_q;

	always_ff @(posedge clk) begin
		if (ctrl.load)
			idx_q <= load_idx;
		else if (ctrl.shift)
			idx_q <= next_idx;
	end

	assign idx       = idx_q;
	assign match_out = match_in | (live && (idx_q[KEY_BITS-1:0] == key));
endmodule
